@@ rtl/core/rpmc_pkg.sv @@
// Package for the radio power mode controller: field widths, mode, command,
// status and radio setting codes, and the state and result types.
// No dependencies.
`default_nettype none

package rpmc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_W      = 16;

  localparam logic [CFG_W-1:0] DELAY_RESET = 16'd100;
  localparam logic [CFG_W-1:0] IDLE_RESET  = 16'd0;

  typedef enum logic [1:0] {
    CMD_REQUEST  = 2'd0,
    CMD_ACTIVITY = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_DEACT    = 3'd0,
    MODE_ACTIVE   = 3'd1,
    MODE_IDLE     = 3'd2,
    MODE_SB_LBT   = 3'd3,
    MODE_SB_NOLBT = 3'd4,
    MODE_DEEP     = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_PHY_FAIL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RADIO_OFF                 = 3'd0,
    RADIO_LOW_LATENCY         = 3'd1,
    RADIO_LOW_LATENCY_STANDBY = 3'd2,
    RADIO_LBT_STANDBY         = 3'd3,
    RADIO_NON_LBT_STANDBY     = 3'd4
  } radio_t;

  localparam int CFG_IDX_DELAY = 0;
  localparam int CFG_IDX_IDLE  = 1;

  typedef struct packed {
    logic [2:0]            mode_now;
    logic [2:0]            mode_target;
    logic                  in_trans;
    logic [TIMER_BITS-1:0] delay_left;
    logic                  delay_run;
    logic [TIMER_BITS-1:0] idle_left;
    logic                  idle_run;
  } ctl_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] current_mode;
    logic       pending;
    logic [2:0] target_mode;
    logic       phy_strobe;
    logic       phy_activate;
    logic [2:0] radio_setting;
  } res_t;

  // Working copy of the state plus the per-word outputs built so far.
  typedef struct packed {
    ctl_t       s;
    logic [1:0] status;
    logic       strobe;
    logic       activate;
    logic [2:0] radio;
  } step_t;

  function automatic logic [2:0] radio_of_mode(input logic [2:0] m);
    logic [2:0] r;
    case (m)
      MODE_DEACT:    r = RADIO_OFF;
      MODE_ACTIVE:   r = RADIO_LOW_LATENCY;
      MODE_IDLE:     r = RADIO_LOW_LATENCY_STANDBY;
      MODE_SB_LBT:   r = RADIO_LBT_STANDBY;
      MODE_SB_NOLBT: r = RADIO_NON_LBT_STANDBY;
      default:       r = RADIO_OFF;
    endcase
    return r;
  endfunction

  // Saturates a register value into the countdown width.
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_W-1:0] v);
    logic [32:0] wide;
    logic [32:0] max;
    wide = 33'(v);
    max  = (33'd1 << TIMER_BITS) - 33'd1;
    if (wide > max) begin
      return max[TIMER_BITS-1:0];
    end
    return wide[TIMER_BITS-1:0];
  endfunction

  // Issues the PHY command for a valid mode and updates the state.
  function automatic step_t perform(input step_t st, input logic [2:0] m, input logic ok,
                                    input logic [CFG_W-1:0] delay_cfg,
                                    input logic [CFG_W-1:0] idle_cfg);
    step_t r;
    logic  delayed;
    r        = st;
    delayed  = (m >= MODE_IDLE) && (delay_cfg != '0);
    r.strobe = 1'b1;
    r.radio  = radio_of_mode(m);
    r.activate = !((m == MODE_DEACT) || (m == MODE_DEEP));
    if (!ok) begin
      r.s.in_trans = 1'b0;
      r.status     = ST_PHY_FAIL;
      return r;
    end
    if (delayed) begin
      r.s.in_trans   = 1'b1;
      r.s.delay_left = timer_load(delay_cfg);
      r.s.delay_run  = 1'b1;
    end else begin
      r.s.mode_now = m;
      r.s.in_trans = 1'b0;
    end
    if ((m != MODE_ACTIVE) && (m != MODE_DEACT) && (idle_cfg != '0)) begin
      r.s.idle_left = timer_load(idle_cfg);
      r.s.idle_run  = 1'b1;
    end else begin
      r.s.idle_run = 1'b0;
    end
    return r;
  endfunction

  function automatic step_t request(input step_t st, input logic [2:0] m, input logic ok,
                                    input logic [CFG_W-1:0] delay_cfg,
                                    input logic [CFG_W-1:0] idle_cfg);
    step_t r;
    r = st;
    if (m > MODE_DEEP) begin
      r.status = ST_INVALID;
      return r;
    end
    if (m == r.s.mode_now) begin
      return r;
    end
    r.s.mode_target = m;
    return perform(r, m, ok, delay_cfg, idle_cfg);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/radio_power_mode_controller.sv @@
// Radio power mode controller top level: mode state, delay and inactivity
// countdowns, and a two-word result queue. Depends on rpmc_pkg.
//
// Usage: each input word carries cmd (mode request, activity, or 1 ms tick),
// the requested mode and the PHY outcome for any command issued in that step.
// A word is taken when in_valid is high and in_stall is low; it is processed
// in that same cycle, and its single result word is registered for the output.
// One word is accepted every cycle while in_stall is low. A skid register
// behind the result register lets one more word be accepted while the
// receiver holds out_stall high; in_stall rises only when both result
// registers are full, so nothing is lost or repeated.
// The write port (cfg_we, cfg_index, cfg_data) sets the transition delay
// (index 0) and the inactivity length (index 1); the user is to use it only
// while idle, as the block itself does not enforce this.
// Synchronous reset puts the block in deactivated mode with both countdowns
// stopped, the delay register at 100 ticks, inactivity disabled, and the
// result queue empty.
`default_nettype none

module radio_power_mode_controller
  import rpmc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       cmd,
  input  wire logic [2:0]       mode,
  input  wire logic             phy_ok,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [1:0]            status,
  output logic [2:0]            current_mode,
  output logic                  pending,
  output logic [2:0]            target_mode,
  output logic                  phy_strobe,
  output logic                  phy_activate,
  output logic [2:0]            radio_setting
);

  logic [CFG_W-1:0] delay_cfg;
  logic [CFG_W-1:0] idle_cfg;
  ctl_t             ctl;
  ctl_t             ctl_next;
  res_t             res_next;
  res_t             out_word;
  res_t             skid_word;
  logic             skid_valid;
  logic             in_accept;
  logic             out_take;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_cfg <= DELAY_RESET;
      idle_cfg  <= IDLE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == 1'(CFG_IDX_DELAY)) begin
        delay_cfg <= cfg_data;
      end else begin
        idle_cfg <= cfg_data;
      end
    end
  end

  always_comb begin
    step_t st;
    st        = '0;
    st.s      = ctl;
    st.status = ST_OK;
    case (cmd)
      CMD_REQUEST: begin
        st = request(st, mode, phy_ok, delay_cfg, idle_cfg);
      end
      CMD_ACTIVITY: begin
        if ((st.s.mode_now != MODE_ACTIVE) && !st.s.in_trans) begin
          st = perform(st, MODE_ACTIVE, phy_ok, delay_cfg, idle_cfg);
        end
        if (st.s.idle_run) begin
          st.s.idle_left = timer_load(idle_cfg);
        end
      end
      CMD_TICK: begin
        // The delay countdown is serviced first, so an inactivity request in
        // the same tick sees the completed mode.
        if (st.s.delay_run) begin
          if (st.s.delay_left <= TIMER_BITS'(1)) begin
            st.s.delay_left = '0;
            st.s.delay_run  = 1'b0;
            if (st.s.in_trans) begin
              st.s.mode_now = st.s.mode_target;
              st.s.in_trans = 1'b0;
            end
          end else begin
            st.s.delay_left = st.s.delay_left - TIMER_BITS'(1);
          end
        end
        if (st.s.idle_run) begin
          if (st.s.idle_left <= TIMER_BITS'(1)) begin
            st.s.idle_left = '0;
            st.s.idle_run  = 1'b0;
            st = request(st, MODE_IDLE, phy_ok, delay_cfg, idle_cfg);
          end else begin
            st.s.idle_left = st.s.idle_left - TIMER_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
    ctl_next               = st.s;
    res_next.status        = st.status;
    res_next.current_mode  = st.s.mode_now;
    res_next.pending       = st.s.in_trans;
    res_next.target_mode   = st.s.mode_target;
    res_next.phy_strobe    = st.strobe;
    res_next.phy_activate  = st.activate;
    res_next.radio_setting = st.radio;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (in_accept) begin
      ctl <= ctl_next;
    end
  end

  // Result register plus skid register; the skid fills only when the result
  // register is held by the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_take) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (in_accept) begin
          out_word  <= res_next;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (in_accept) begin
        skid_word  <= res_next;
        skid_valid <= 1'b1;
      end
    end
  end

  assign status        = out_word.status;
  assign current_mode  = out_word.current_mode;
  assign pending       = out_word.pending;
  assign target_mode   = out_word.target_mode;
  assign phy_strobe    = out_word.phy_strobe;
  assign phy_activate  = out_word.phy_activate;
  assign radio_setting = out_word.radio_setting;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a word while the result register is empty");

  a_no_cmd_no_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !phy_strobe) |-> (!phy_activate && (radio_setting == RADIO_OFF)))
    else $error("PHY fields set without a PHY command");

  a_invalid_no_cmd: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_INVALID)) |-> !phy_strobe)
    else $error("PHY command issued for an invalid mode");

  a_stall_queue_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && in_accept && !skid_valid) |=> skid_valid)
    else $error("accepted word lost while the receiver stalls");

endmodule

`default_nettype wire
